### hdl/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and codes for the round-robin slice scheduler: item and
// result layouts, command and status codes, sequencer states and the
// table write-enable group.
// ----------------------------------------------------------------------------
package rrss_pkg;

    // Command codes carried in the mode field of an item
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_RESTART  = 2'd2;
    localparam logic [1:0] MODE_CLEAR    = 2'd3;

    // Status codes returned with each result
    localparam logic [2:0] STAT_LOADED     = 3'd0;
    localparam logic [2:0] STAT_DISPATCHED = 3'd1;
    localparam logic [2:0] STAT_ALL_DONE   = 3'd2;
    localparam logic [2:0] STAT_TABLE_FULL = 3'd3;
    localparam logic [2:0] STAT_RESET_ACK  = 3'd4;

    // Register map
    localparam int          PADDR_W        = 2;
    localparam logic [1:0]  ADDR_QUANTUM   = 2'd0;
    localparam logic [15:0] QUANTUM_RESET  = 16'd4;
    localparam int          ELAPSED_W      = 20;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] process_id;
        logic [15:0] burst_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [15:0]          served_id;
        logic [15:0]          remaining_time;
        logic [ELAPSED_W-1:0] elapsed_time;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_RESTART
    } t_state;

    // Write enables for the three table arrays
    typedef struct packed {
        logic id;
        logic orig;
        logic rem;
    } t_tbl_we;

endpackage

### hdl/rrss_table.sv
// ----------------------------------------------------------------------------
// rrss_table
// Process table: id, original burst and remaining burst arrays. One write
// address and one read address, with registered read data, shared by all three arrays.
// ----------------------------------------------------------------------------
module rrss_table #(
    parameter int MAX_PROCESSES = 16,
    parameter int BURST_WIDTH   = 16,
    parameter int IDX_W         = 4
) (
    input  logic                   i_clk,
    input  rrss_pkg::t_tbl_we      i_we,
    input  logic [IDX_W-1:0]       i_wr_addr,
    input  logic [15:0]            i_wr_id,
    input  logic [BURST_WIDTH-1:0] i_wr_orig,
    input  logic [BURST_WIDTH-1:0] i_wr_rem,
    input  logic                   i_rd_en,
    input  logic [IDX_W-1:0]       i_rd_addr,
    output logic [15:0]            o_rd_id,
    output logic [BURST_WIDTH-1:0] o_rd_orig,
    output logic [BURST_WIDTH-1:0] o_rd_rem
);
    import rrss_pkg::*;

    logic [15:0]            id_mem   [MAX_PROCESSES];
    logic [BURST_WIDTH-1:0] orig_mem [MAX_PROCESSES];
    logic [BURST_WIDTH-1:0] rem_mem  [MAX_PROCESSES];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we.id) begin
            id_mem[i_wr_addr] <= i_wr_id;
        end
        if (i_we.orig) begin
            orig_mem[i_wr_addr] <= i_wr_orig;
        end
        if (i_we.rem) begin
            rem_mem[i_wr_addr] <= i_wr_rem;
        end
    end

    // Registered read port; hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_id   <= id_mem[i_rd_addr];
            o_rd_orig <= orig_mem[i_rd_addr];
            o_rd_rem  <= rem_mem[i_rd_addr];
        end
    end

endmodule

### hdl/rrss_slice_unit.sv
// ----------------------------------------------------------------------------
// rrss_slice_unit
// Shared slice arithmetic: tests an entry for work left, takes
// min(remaining, quantum), charges it to the entry and to the saturating
// elapsed clock.
// ----------------------------------------------------------------------------
module rrss_slice_unit #(
    parameter int BURST_WIDTH = 16
) (
    input  logic [BURST_WIDTH-1:0]         i_rem,
    input  logic [15:0]                    i_quantum,
    input  logic [rrss_pkg::ELAPSED_W-1:0] i_elapsed,
    output logic                           o_has_work,
    output logic [BURST_WIDTH-1:0]         o_new_rem,
    output logic [rrss_pkg::ELAPSED_W-1:0] o_new_elapsed
);
    import rrss_pkg::*;

    localparam int CW = (BURST_WIDTH > 16) ? BURST_WIDTH : 16;

    logic [15:0]        q_eff;
    logic [CW-1:0]      rem_w;
    logic [CW-1:0]      q_w;
    logic [15:0]        slice;
    logic [ELAPSED_W:0] sum;

    // Treat a zero quantum as one
    assign q_eff = (i_quantum == 16'd0) ? 16'd1 : i_quantum;
    assign rem_w = CW'(i_rem);
    assign q_w   = CW'(q_eff);

    // Slice never exceeds the quantum, so 16 bits hold it
    assign slice      = (rem_w < q_w) ? 16'(rem_w) : q_eff;
    assign o_has_work = (i_rem != '0);
    assign o_new_rem  = BURST_WIDTH'(rem_w - CW'(slice));

    // Saturate the clock at its full-scale value
    assign sum           = (ELAPSED_W+1)'(i_elapsed) + (ELAPSED_W+1)'(slice);
    assign o_new_elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];

endmodule

### hdl/round_robin_slice_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin time-slice scheduler over a table of processes, with an APB
// register for the time quantum.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low, and every item
// returns exactly one result, shown on o_result for one cycle with o_valid
// high; the receiver cannot stall, so it must capture the result in that
// cycle. Load and clear complete from idle (busy stays low), as do a
// dispatch or a restart on an empty table. A dispatch reads the table one
// entry per cycle from the scan position, wrapping, until it finds an entry
// with work left or has examined every entry; the single table read port
// sets this pace. Restart copies original bursts back one entry per cycle.
// The quantum register sits at byte address 0; the user must write it only
// while busy is low, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler #(
    parameter int MAX_PROCESSES = 16,
    parameter int BURST_WIDTH   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Command channel
    input  logic                         start,
    output logic                         busy,
    input  rrss_pkg::t_in_item           i_item,
    // Result channel
    output logic                         o_valid,
    output rrss_pkg::t_out_item          o_result,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rrss_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import rrss_pkg::*;

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    t_state                 r_state,     n_state;
    logic [15:0]            r_quantum;
    logic [CNT_W-1:0]       r_count,     n_count;
    logic [IDX_W-1:0]       r_scan,      n_scan;
    logic [ELAPSED_W-1:0]   r_elapsed,   n_elapsed;
    logic [IDX_W-1:0]       r_rd_addr,   n_rd_addr;
    logic [CNT_W-1:0]       r_left,      n_left;
    logic [IDX_W-1:0]       r_chk_idx,   n_chk_idx;
    logic                   r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]       r_hit_idx,   n_hit_idx;
    logic [15:0]            r_hit_id,    n_hit_id;
    logic [BURST_WIDTH-1:0] r_hit_rem,   n_hit_rem;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out,       n_out;

    t_tbl_we                tbl_we;
    logic [IDX_W-1:0]       tbl_wr_addr;
    logic [BURST_WIDTH-1:0] tbl_wr_rem;
    logic                   tbl_rd_en;
    logic [15:0]            rd_id;
    logic [BURST_WIDTH-1:0] rd_orig;
    logic [BURST_WIDTH-1:0] rd_rem;

    logic [BURST_WIDTH-1:0] unit_rem;
    logic                   unit_has_work;
    logic [BURST_WIDTH-1:0] unit_new_rem;
    logic [ELAPSED_W-1:0]   unit_new_elapsed;

    logic                   accept;
    logic                   cfg_wr;
    logic [BURST_WIDTH-1:0] load_burst;

    // Next table index, wrapping over the loaded entries
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] a_inc;
        a_inc = CNT_W'(a) + CNT_W'(1);
        return (a_inc == cnt) ? '0 : IDX_W'(a_inc);
    endfunction

    assign accept     = start && !busy;
    assign busy       = (r_state != ST_IDLE);
    assign load_burst = BURST_WIDTH'(i_item.burst_time);

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_QUANTUM);
    assign prdata = (paddr == ADDR_QUANTUM) ? {16'd0, r_quantum} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (cfg_wr) begin
            r_quantum <= pwdata[15:0];
        end
    end

    rrss_table #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .BURST_WIDTH   (BURST_WIDTH),
        .IDX_W         (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (tbl_we),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_id   (i_item.process_id),
        .i_wr_orig (load_burst),
        .i_wr_rem  (tbl_wr_rem),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (r_rd_addr),
        .o_rd_id   (rd_id),
        .o_rd_orig (rd_orig),
        .o_rd_rem  (rd_rem)
    );

    // Share the slice unit: scan tests read data, update charges the hit
    assign unit_rem = (r_state == ST_UPDATE) ? r_hit_rem : rd_rem;

    rrss_slice_unit #(
        .BURST_WIDTH (BURST_WIDTH)
    ) u_slice (
        .i_rem         (unit_rem),
        .i_quantum     (r_quantum),
        .i_elapsed     (r_elapsed),
        .o_has_work    (unit_has_work),
        .o_new_rem     (unit_new_rem),
        .o_new_elapsed (unit_new_elapsed)
    );

    // Sequencer: next state, table controls and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan      = r_scan;
        n_elapsed   = r_elapsed;
        n_rd_addr   = r_rd_addr;
        n_left      = r_left;
        n_chk_idx   = r_chk_idx;
        n_chk_valid = r_chk_valid;
        n_hit_idx   = r_hit_idx;
        n_hit_id    = r_hit_id;
        n_hit_rem   = r_hit_rem;
        n_out_valid = 1'b0;
        n_out       = r_out;
        tbl_we      = '0;
        tbl_wr_addr = r_chk_idx;
        tbl_wr_rem  = rd_orig;
        tbl_rd_en   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rd_addr   = r_scan;
                    n_left      = r_count;
                    n_chk_valid = 1'b0;
                    case (i_item.mode)
                        MODE_LOAD: begin
                            n_out_valid = 1'b1;
                            if (r_count == CNT_W'(MAX_PROCESSES)) begin
                                n_out = '{STAT_TABLE_FULL, 16'd0, 16'd0, r_elapsed};
                            end else begin
                                tbl_we      = '{id: 1'b1, orig: 1'b1, rem: 1'b1};
                                tbl_wr_addr = IDX_W'(r_count);
                                tbl_wr_rem  = load_burst;
                                n_count     = r_count + CNT_W'(1);
                                n_out       = '{STAT_LOADED, i_item.process_id,
                                                16'(load_burst), r_elapsed};
                            end
                        end
                        MODE_DISPATCH: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{STAT_ALL_DONE, 16'd0, 16'd0, r_elapsed};
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        MODE_RESTART: begin
                            n_scan    = '0;
                            n_elapsed = '0;
                            n_rd_addr = '0;
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out = '{STAT_RESET_ACK, 16'd0, 16'd0, '0};
                            end else begin
                                n_state = ST_RESTART;
                            end
                        end
                        default: begin
                            n_count     = '0;
                            n_scan      = '0;
                            n_elapsed   = '0;
                            n_out_valid = 1'b1;
                            n_out = '{STAT_RESET_ACK, 16'd0, 16'd0, '0};
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (r_chk_valid && unit_has_work) begin
                    // Hold the hit for the update step
                    n_hit_idx   = r_chk_idx;
                    n_hit_id    = rd_id;
                    n_hit_rem   = rd_rem;
                    n_chk_valid = 1'b0;
                    n_state     = ST_UPDATE;
                end else if (r_left != '0) begin
                    // Advance the read one entry
                    tbl_rd_en   = 1'b1;
                    n_chk_idx   = r_rd_addr;
                    n_chk_valid = 1'b1;
                    n_rd_addr   = next_idx(r_rd_addr, r_count);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    // Every entry examined without work left
                    n_chk_valid = 1'b0;
                    n_out_valid = 1'b1;
                    n_out = '{STAT_ALL_DONE, 16'd0, 16'd0, r_elapsed};
                    n_state = ST_IDLE;
                end
            end

            ST_UPDATE: begin
                tbl_we.rem  = 1'b1;
                tbl_wr_addr = r_hit_idx;
                tbl_wr_rem  = unit_new_rem;
                n_elapsed   = unit_new_elapsed;
                n_scan      = next_idx(r_hit_idx, r_count);
                n_out_valid = 1'b1;
                n_out = '{STAT_DISPATCHED, r_hit_id, 16'(unit_new_rem),
                          unit_new_elapsed};
                n_state = ST_IDLE;
            end

            ST_RESTART: begin
                // Copy back the entry read in the previous cycle
                if (r_chk_valid) begin
                    tbl_we.rem  = 1'b1;
                    tbl_wr_addr = r_chk_idx;
                    tbl_wr_rem  = rd_orig;
                end
                if (r_left != '0) begin
                    tbl_rd_en   = 1'b1;
                    n_chk_idx   = r_rd_addr;
                    n_chk_valid = 1'b1;
                    n_rd_addr   = next_idx(r_rd_addr, r_count);
                    n_left      = r_left - CNT_W'(1);
                end else begin
                    n_chk_valid = 1'b0;
                    n_out_valid = 1'b1;
                    n_out = '{STAT_RESET_ACK, 16'd0, 16'd0, '0};
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_elapsed   <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_elapsed   <= n_elapsed;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_left    <= n_left;
        r_chk_idx <= n_chk_idx;
        r_hit_idx <= n_hit_idx;
        r_hit_id  <= n_hit_id;
        r_hit_rem <= n_hit_rem;
        r_out     <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

### test/round_robin_slice_scheduler_tb.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_tb
// Self-checking bench for the round-robin slice scheduler. A queue of items
// feeds a falling-edge driver with random gaps between items. A rising-edge
// monitor predicts one result per accepted item from its own copy of the
// process table and compares every result field by field. The quantum
// register is written over the APB port between phases, once the block has
// drained, and read back after each write.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrss_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int PHASE_ITEMS  = 135;
    localparam int SETTLE_TICKS = 24;

    typedef struct {
        t_in_item    item;
        int unsigned gap;
    } t_stim;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               start    = 1'b0;
    logic               busy;
    t_in_item           i_item   = '0;
    logic               o_valid;
    t_out_item          o_result;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Stimulus and expectation stores
    t_stim              item_queue[$];
    t_out_item          result_queue[$];
    logic               item_taken   = 1'b0;
    int unsigned        gap_left     = 0;
    int                 error_count  = 0;
    int                 items_queued = 0;

    // Predictor state
    logic [15:0]        proc_id_tbl    [NUM_SLOTS];
    logic [15:0]        proc_burst_init[NUM_SLOTS];
    logic [15:0]        proc_burst_left[NUM_SLOTS];
    int                 proc_count;
    int                 next_slot;
    logic [19:0]        clock_total;
    logic [15:0]        slice_quantum;

    round_robin_slice_scheduler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Apply one item to the predicted table and return its result
    function automatic t_out_item schedule_step(input t_in_item it);
        t_out_item   res;
        logic [15:0] q;
        logic [15:0] slice;
        logic [20:0] sum;
        int          first;
        int          p;
        res = '0;
        case (it.mode)
            MODE_LOAD: begin
                if (proc_count >= NUM_SLOTS) begin
                    res.status       = STAT_TABLE_FULL;
                    res.elapsed_time = clock_total;
                end else begin
                    proc_id_tbl[proc_count]     = it.process_id;
                    proc_burst_init[proc_count] = it.burst_time;
                    proc_burst_left[proc_count] = it.burst_time;
                    proc_count++;
                    res.status         = STAT_LOADED;
                    res.served_id      = it.process_id;
                    res.remaining_time = it.burst_time;
                    res.elapsed_time   = clock_total;
                end
            end
            MODE_DISPATCH: begin
                q = (slice_quantum == 16'd0) ? 16'd1 : slice_quantum;
                res.status       = STAT_ALL_DONE;
                res.elapsed_time = clock_total;
                if (proc_count > 0) begin
                    first = next_slot % proc_count;
                    for (int k = 0; k < proc_count; k++) begin
                        p = (first + k) % proc_count;
                        if (res.status == STAT_ALL_DONE && proc_burst_left[p] != 16'd0) begin
                            slice = (proc_burst_left[p] < q) ? proc_burst_left[p] : q;
                            proc_burst_left[p] = proc_burst_left[p] - slice;
                            sum = {1'b0, clock_total} + 21'(slice);
                            clock_total = sum[20] ? 20'hFFFFF : sum[19:0];
                            next_slot = (p + 1) % proc_count;
                            res.status         = STAT_DISPATCHED;
                            res.served_id      = proc_id_tbl[p];
                            res.remaining_time = proc_burst_left[p];
                            res.elapsed_time   = clock_total;
                        end
                    end
                end
            end
            MODE_RESTART: begin
                for (int k = 0; k < proc_count; k++)
                    proc_burst_left[k] = proc_burst_init[k];
                next_slot   = 0;
                clock_total = '0;
                res.status  = STAT_RESET_ACK;
            end
            default: begin
                proc_count  = 0;
                next_slot   = 0;
                clock_total = '0;
                res.status  = STAT_RESET_ACK;
            end
        endcase
        return res;
    endfunction

    // Drive items at the falling edge; hold each one until accepted
    always @(negedge i_clk) begin : drive_items
        t_stim nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            // hold the current item
        end else if (gap_left != 0) begin
            start <= 1'b0;
            gap_left--;
        end else if (item_queue.size() != 0) begin
            nxt      = item_queue.pop_front();
            start    <= 1'b1;
            i_item   <= nxt.item;
            gap_left = nxt.gap;
        end else begin
            start <= 1'b0;
        end
    end

    // Track config writes, predict accepted items, check results
    always @(posedge i_clk) begin : watch_results
        t_out_item want;
        if (!i_rst_n) begin
            proc_count    = 0;
            next_slot     = 0;
            clock_total   = '0;
            slice_quantum = QUANTUM_RESET;
            item_taken    <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_QUANTUM)
                slice_quantum = pwdata[15:0];
            item_taken <= start && !busy;
            if (start && !busy)
                result_queue.push_back(schedule_step(i_item));
            if (o_valid) begin
                if (result_queue.size() == 0) begin
                    flag_error("result with no item outstanding");
                end else begin
                    want = result_queue.pop_front();
                    if (o_result.status !== want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             o_result.status, want.status));
                    if (o_result.served_id !== want.served_id)
                        flag_error($sformatf("served_id got %h want %h",
                                             o_result.served_id, want.served_id));
                    if (o_result.remaining_time !== want.remaining_time)
                        flag_error($sformatf("remaining_time got %0d want %0d",
                                             o_result.remaining_time, want.remaining_time));
                    if (o_result.elapsed_time !== want.elapsed_time)
                        flag_error($sformatf("elapsed_time got %0d want %0d",
                                             o_result.elapsed_time, want.elapsed_time));
                end
            end
        end
    end

    task automatic add_item(input logic [1:0] mode, input logic [15:0] pid,
                            input logic [15:0] burst, input int unsigned gap);
        t_stim s;
        s.item.mode       = mode;
        s.item.process_id = pid;
        s.item.burst_time = burst;
        s.gap             = gap;
        item_queue.push_back(s);
        items_queued++;
    endtask

    // Wait until every item has gone out and every result has come back
    task automatic wait_drained();
        while (item_queue.size() != 0 || start || busy || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Write the quantum register, then read it back
    task automatic set_quantum(input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_QUANTUM;
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== value)
            flag_error($sformatf("quantum read back %h want %h", prdata[15:0], value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One well-formed scheduling session: load, dispatch to completion,
    // sometimes restart and replay, sometimes mixed with random noise
    task automatic queue_session(input int q_eff, input int unsigned gap_max);
        int          n_proc;
        int          burst_cap;
        int          dispatches;
        int unsigned roll;
        logic [15:0] b;
        roll = $urandom_range(0, 9);
        if (roll < 8)
            add_item(MODE_CLEAR, 16'($urandom), 16'($urandom),
                     $urandom_range(0, gap_max));
        n_proc     = ($urandom_range(0, 4) == 0) ? NUM_SLOTS : int'($urandom_range(1, 6));
        burst_cap  = (q_eff >= 4096) ? 65535 : 3 * q_eff + 2;
        dispatches = 1;
        for (int i = 0; i < n_proc; i++) begin
            b = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, burst_cap));
            dispatches += (int'(b) + q_eff - 1) / q_eff;
            add_item(MODE_LOAD, 16'($urandom), b, $urandom_range(0, gap_max));
        end
        // overflow the table when it was filled
        if (n_proc == NUM_SLOTS)
            repeat ($urandom_range(1, 2))
                add_item(MODE_LOAD, 16'($urandom), 16'($urandom),
                         $urandom_range(0, gap_max));
        // noise: fully random items
        if (roll == 9)
            repeat ($urandom_range(1, 6))
                add_item(2'($urandom), 16'($urandom), 16'($urandom),
                         $urandom_range(0, gap_max));
        repeat (dispatches)
            add_item(MODE_DISPATCH, 16'($urandom), 16'($urandom),
                     $urandom_range(0, gap_max));
        if ($urandom_range(0, 2) == 0) begin
            add_item(MODE_RESTART, 16'($urandom), 16'($urandom),
                     $urandom_range(0, gap_max));
            repeat ($urandom_range(1, dispatches))
                add_item(MODE_DISPATCH, 16'($urandom), 16'($urandom),
                         $urandom_range(0, gap_max));
        end
    endtask

    // Stimulus sequence
    initial begin : stimulus
        logic [15:0] quanta[6];
        int          q_eff;
        int          phase_start;
        int unsigned gap_max;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, zero burst, wrap, restart, clear, max fields
        add_item(MODE_DISPATCH, 16'h0000, 16'h0000, 0);
        add_item(MODE_RESTART,  16'hFFFF, 16'hFFFF, 1);
        add_item(MODE_LOAD,     16'h0000, 16'h0000, 0);
        add_item(MODE_LOAD,     16'hFFFF, 16'd5,    3);
        add_item(MODE_LOAD,     16'h5A5A, 16'd3,    0);
        repeat (4) add_item(MODE_DISPATCH, 16'hFFFF, 16'hFFFF, 0);
        add_item(MODE_RESTART,  16'h0000, 16'h0000, 2);
        add_item(MODE_DISPATCH, 16'h0000, 16'h0000, 0);
        add_item(MODE_LOAD,     16'h1234, 16'hFFFF, 0);
        add_item(MODE_DISPATCH, 16'h0000, 16'h0000, 5);
        add_item(MODE_DISPATCH, 16'h0000, 16'h0000, 0);
        add_item(MODE_CLEAR,    16'hFFFF, 16'hFFFF, 0);
        add_item(MODE_DISPATCH, 16'h0000, 16'h0000, 13);
        wait_drained();

        // Random phases, one quantum setting each, extremes included
        quanta[0] = 16'd1;
        quanta[1] = 16'd0;
        quanta[2] = 16'hFFFF;
        quanta[3] = 16'($urandom_range(2, 20));
        quanta[4] = QUANTUM_RESET;
        quanta[5] = 16'($urandom_range(1, 65535));
        for (int ph = 0; ph < 6; ph++) begin
            set_quantum(quanta[ph]);
            q_eff       = (quanta[ph] == 16'd0) ? 1 : int'(quanta[ph]);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                // some sessions and one whole phase run back to back
                gap_max = (ph == 3 || $urandom_range(0, 3) == 0) ? 0 : 13;
                queue_session(q_eff, gap_max);
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
